// ===== src/assert_macros.svh =====
// assertion macros used by the rtl file box_min_gap_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bmg_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmg_pkg
// shared constants, codes and types of the box minimum-gap checker
// ---------------------------------------------------------------------------
package bmg_pkg;

  localparam int SLOTS    = 64;
  localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_W   = 6;
  localparam int MODE_W   = 2;
  localparam int COORD_W  = 20;
  localparam int SIZE_W   = 19;
  localparam int CFG_W    = 16;
  localparam int PROD_W   = 2 * CFG_W;
  localparam int MARGIN_W = PROD_W - 8;
  localparam int GAP_W    = COORD_W + 1;
  localparam int CFG_IDX_W = 1;

  localparam int IN_FIELDS_W  = SLOT_W + 2 * COORD_W + 2 * SIZE_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + 2 * COORD_W + 2 * SIZE_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [SLOT_W:0]  SLOT_LIMIT = (SLOT_W + 1)'(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(SLOTS - 1);

  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHECK = 2'd2;
  localparam logic [MODE_W-1:0] MODE_LIST  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GRID  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 1'd1;

  localparam logic [CFG_W-1:0] MIN_GRID_RESET  = 16'd256;
  localparam logic [CFG_W-1:0] GRID_SIZE_RESET = 16'd160;

  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [SIZE_W-1:0]         SIZE_MAX  = {SIZE_W{1'b1}};

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [SIZE_W-1:0]         size_w;
    logic [SIZE_W-1:0]         size_h;
  } box_entry_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] region_x;
    logic signed [COORD_W-1:0] region_y;
    logic [SIZE_W-1:0]         region_w;
    logic [SIZE_W-1:0]         region_h;
  } slot_eval_t;

endpackage

// ===== src/bmg_slot_eval.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmg_slot_eval
// gap test of the moved box against one stored box, and the stored box
// grown by the margin
// ---------------------------------------------------------------------------
module bmg_slot_eval (
  input  bmg_pkg::box_entry_t              entry,
  input  logic signed [bmg_pkg::COORD_W-1:0] move_x,
  input  logic signed [bmg_pkg::COORD_W-1:0] move_y,
  input  logic [bmg_pkg::SIZE_W-1:0]       move_w,
  input  logic [bmg_pkg::SIZE_W-1:0]       move_h,
  input  logic [bmg_pkg::PROD_W-1:0]       margin_prod,
  output bmg_pkg::slot_eval_t              result
);
  import bmg_pkg::*;

  localparam int EXT_W = COORD_W + 2;
  localparam int SUM_W = MARGIN_W + 2;

  function automatic logic [GAP_W-1:0] gap1d(
    input logic signed [COORD_W-1:0] a,
    input logic [SIZE_W-1:0]         aw,
    input logic signed [COORD_W-1:0] b,
    input logic [SIZE_W-1:0]         bw
  );
    logic signed [EXT_W-1:0] a_e;
    logic signed [EXT_W-1:0] b_e;
    logic signed [EXT_W-1:0] g1;
    logic signed [EXT_W-1:0] g2;
    logic signed [EXT_W-1:0] g;
    a_e = {{(EXT_W-COORD_W){a[COORD_W-1]}}, a};
    b_e = {{(EXT_W-COORD_W){b[COORD_W-1]}}, b};
    g1 = b_e - a_e - $signed({{(EXT_W-SIZE_W){1'b0}}, aw});
    g2 = a_e - b_e - $signed({{(EXT_W-SIZE_W){1'b0}}, bw});
    g = (g1 > g2) ? g1 : g2;
    return (g > 0) ? g[GAP_W-1:0] : '0;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_edge(
    input logic signed [COORD_W-1:0] p,
    input logic [MARGIN_W-1:0]       m
  );
    logic signed [SUM_W-1:0] d;
    d = {{(SUM_W-COORD_W){p[COORD_W-1]}}, p} - $signed({2'b00, m});
    if (d < $signed({{(SUM_W-COORD_W){1'b1}}, COORD_MIN})) begin
      return COORD_MIN;
    end else if (d > $signed({{(SUM_W-COORD_W){1'b0}}, COORD_MAX})) begin
      return COORD_MAX;
    end
    return d[COORD_W-1:0];
  endfunction

  function automatic logic [SIZE_W-1:0] sat_size(
    input logic [SIZE_W-1:0]   s,
    input logic [MARGIN_W-1:0] m
  );
    logic [SUM_W-1:0] t;
    t = {{(SUM_W-SIZE_W){1'b0}}, s} + {1'b0, m, 1'b0};
    return (t > {{(SUM_W-SIZE_W){1'b0}}, SIZE_MAX}) ? SIZE_MAX : t[SIZE_W-1:0];
  endfunction

  logic [GAP_W-1:0]    gap_x;
  logic [GAP_W-1:0]    gap_y;
  logic [MARGIN_W-1:0] margin;

  assign gap_x  = gap1d(move_x, move_w, entry.pos_x, entry.size_w);
  assign gap_y  = gap1d(move_y, move_h, entry.pos_y, entry.size_h);
  assign margin = margin_prod[PROD_W-1:8];

  // gap scaled to the 8 fractional bits of the margin product
  assign result.hit =
    ({{(PROD_W-GAP_W-8){1'b0}}, gap_x, 8'b0} < margin_prod) &&
    ({{(PROD_W-GAP_W-8){1'b0}}, gap_y, 8'b0} < margin_prod);
  assign result.region_x = sat_edge(entry.pos_x, margin);
  assign result.region_y = sat_edge(entry.pos_y, margin);
  assign result.region_w = sat_size(entry.size_w, margin);
  assign result.region_h = sat_size(entry.size_h, margin);

endmodule

// ===== src/box_min_gap_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// box_min_gap_checker
// table of axis-aligned boxes with write, clear, move check and listing of
// blocked regions grown by the minimum-gap margin
// ---------------------------------------------------------------------------
// Boxes live in a synchronous memory of SLOTS entries with one read and one
// write port (one read per cycle, registered read data); the valid flags are
// flip-flops, so reset needs no clearing pass. Write and clear go straight
// to the final state, which loads the result once the output is free. A move
// check reads the named box, then sweeps every slot at one slot per cycle.
// A listing sweeps the same way and ends on the last region it hands out,
// and stalls on a slot whose region cannot be handed to the output register
// yet. A check or a listing with an invalid named slot, or a listing with no
// other valid slot, also goes straight to the final state. The margin product
// is registered after each configuration write.
module box_min_gap_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // node_slot, pos_x, pos_y, box_width, box_height
  input  logic [bmg_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // mode
  input  logic [bmg_pkg::MODE_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // move_allowed, region_x, region_y, region_width, region_height
  output logic [bmg_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // region_valid
  output logic [0:0]                        m_axis_tuser,
  output logic                              m_axis_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bmg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bmg_pkg::CFG_W-1:0]         cfg_data
);
  import bmg_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_NAMED = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_FINAL = 2'd3;

  localparam logic [SLOTS-1:0] ONE_HOT0 = {{(SLOTS-1){1'b0}}, 1'b1};

  // configuration
  logic [CFG_W-1:0]  min_grid;
  logic [CFG_W-1:0]  grid_size;
  logic [PROD_W-1:0] margin_prod;

  // control
  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [SLOTS-1:0]  slot_valid;
  logic [IDX_W-1:0]  idx;
  logic              fail;
  logic              res_ok;

  // current transaction
  logic [MODE_W-1:0]         op_mode;
  logic [SLOTS-1:0]          op_sel;
  logic signed [COORD_W-1:0] op_x;
  logic signed [COORD_W-1:0] op_y;
  logic [SIZE_W-1:0]         named_w;
  logic [SIZE_W-1:0]         named_h;

  // box memory
  box_entry_t        box_mem [SLOTS];
  box_entry_t        rd_data;
  logic [IDX_W-1:0]  rd_addr;

  // input unpacking
  logic [SLOT_W-1:0]         in_slot;
  box_entry_t                in_entry;
  logic                      in_accept;
  logic                      in_range;
  logic [IDX_W-1:0]          in_idx;
  logic [SLOTS-1:0]          in_sel;
  logic                      in_named;
  logic                      in_others;

  // sweep
  slot_eval_t        eval;
  logic              cand;
  logic [SLOTS-1:0]  pending;
  logic              is_last;
  logic              stall;

  // output
  logic              out_free;
  logic              out_load;
  logic              out_ok_next;
  logic              out_rv_next;
  logic              out_last_next;
  slot_eval_t        out_reg_next;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign in_slot         = s_axis_tdata[SLOT_W-1:0];
  assign in_entry.pos_x  = s_axis_tdata[SLOT_W +: COORD_W];
  assign in_entry.pos_y  = s_axis_tdata[SLOT_W+COORD_W +: COORD_W];
  assign in_entry.size_w = s_axis_tdata[SLOT_W+2*COORD_W +: SIZE_W];
  assign in_entry.size_h = s_axis_tdata[SLOT_W+2*COORD_W+SIZE_W +: SIZE_W];

  assign in_range  = ({1'b0, in_slot} < SLOT_LIMIT);
  assign in_idx    = in_slot[IDX_W-1:0];
  assign in_sel    = in_range ? (ONE_HOT0 << in_idx) : '0;
  assign in_named  = in_range && slot_valid[in_idx];
  assign in_others = |(slot_valid & ~in_sel);

  assign cand     = slot_valid[idx] && !op_sel[idx];
  assign pending  = slot_valid & ~op_sel & ({SLOTS{1'b1}} << idx);
  assign is_last  = ~|(pending & ~(ONE_HOT0 << idx));
  assign out_free = !m_axis_tvalid || m_axis_tready;

  bmg_slot_eval u_eval (
    .entry       (rd_data),
    .move_x      (op_x),
    .move_y      (op_y),
    .move_w      (named_w),
    .move_h      (named_h),
    .margin_prod (margin_prod),
    .result      (eval)
  );

  always_comb begin
    state_next    = state;
    rd_addr       = in_idx;
    stall         = 1'b0;
    out_load      = 1'b0;
    out_ok_next   = 1'b1;
    out_rv_next   = 1'b0;
    out_last_next = 1'b1;
    out_reg_next  = '0;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          priority if (in_named && s_axis_tuser == MODE_CHECK) begin
            state_next = S_NAMED;
          end else if (in_named && in_others && s_axis_tuser == MODE_LIST) begin
            state_next = S_SWEEP;
            rd_addr    = '0;
          end else begin
            state_next = S_FINAL;
          end
        end
      end
      S_NAMED: begin
        rd_addr    = '0;
        state_next = S_SWEEP;
      end
      S_SWEEP: begin
        if (op_mode == MODE_LIST) begin
          stall = cand && !out_free;
          if (cand && out_free) begin
            out_load      = 1'b1;
            out_rv_next   = 1'b1;
            out_last_next = is_last;
            out_reg_next  = eval;
            if (is_last) begin
              state_next = S_IDLE;
            end
          end
        end else if (idx == LAST_IDX) begin
          state_next = S_FINAL;
        end
        rd_addr = stall ? idx : idx + IDX_W'(1);
      end
      S_FINAL: begin
        out_ok_next = res_ok;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // box memory, one read and one write port
  always_ff @(posedge clk) begin
    if (in_accept && s_axis_tuser == MODE_WRITE && in_range) begin
      box_mem[in_idx] <= in_entry;
    end
    rd_data <= box_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      slot_valid    <= '0;
      idx           <= '0;
      fail          <= 1'b0;
      res_ok        <= 1'b1;
      min_grid      <= MIN_GRID_RESET;
      grid_size     <= GRID_SIZE_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MIN_GRID:  min_grid  <= cfg_data;
          CFG_GRID_SIZE: grid_size <= cfg_data;
          default: ;
        endcase
      end
      if (in_accept) begin
        fail   <= 1'b0;
        res_ok <= 1'b1;
        idx    <= '0;
        if (s_axis_tuser == MODE_WRITE && in_range) begin
          slot_valid[in_idx] <= 1'b1;
        end else if (s_axis_tuser == MODE_CLEAR && in_range) begin
          slot_valid[in_idx] <= 1'b0;
        end
      end
      if (state == S_SWEEP) begin
        if (!stall) begin
          idx <= idx + IDX_W'(1);
        end
        if (cand && eval.hit) begin
          fail <= 1'b1;
        end
        if (idx == LAST_IDX) begin
          res_ok <= !(fail || (cand && eval.hit));
        end
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    margin_prod <= {{(PROD_W-CFG_W){1'b0}}, min_grid} * {{(PROD_W-CFG_W){1'b0}}, grid_size};
    if (in_accept) begin
      op_mode <= s_axis_tuser;
      op_sel  <= in_sel;
      op_x    <= in_entry.pos_x;
      op_y    <= in_entry.pos_y;
    end
    if (state == S_NAMED) begin
      named_w <= rd_data.size_w;
      named_h <= rd_data.size_h;
    end
    if (out_load) begin
      m_axis_tdata <= {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}},
                       out_reg_next.region_h, out_reg_next.region_w,
                       out_reg_next.region_y, out_reg_next.region_x, out_ok_next};
      m_axis_tuser <= out_rv_next;
      m_axis_tlast <= out_last_next;
    end
  end

  `ASSERT_NEXT(a_accept_leaves_idle, clk, rst, in_accept, state != S_IDLE, "accepted transaction left the block idle")
  `ASSERT_IMPLIES(a_sweep_mode, clk, rst, state == S_SWEEP, op_mode == MODE_CHECK || op_mode == MODE_LIST, "sweep entered for a write or clear")
  `ASSERT_IMPLIES(a_list_has_region, clk, rst, state == S_SWEEP && op_mode == MODE_LIST, pending != '0, "listing sweep has no region left to emit")
  `ASSERT_IMPLIES(a_load_needs_room, clk, rst, out_load, out_free, "output register overwritten while held")
  `ASSERT_NEXT(a_last_ends_item, clk, rst, out_load && out_last_next, state == S_IDLE, "final result did not end the transaction")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// testbench of the box minimum-gap checker: a directed part covers empty
// slots, the exact margin boundary, saturated regions and the register
// extremes; random traffic then runs under several idle and stall patterns
// and a long output hold-off. Every result is checked field by field against
// a predictor that keeps its own copy of the box table.
// ---------------------------------------------------------------------------
module tb_top;
  import bmg_pkg::*;

  localparam int LIMIT_CYCLES = 1500000;
  localparam int HOLD_CYCLES  = 1500;

  typedef struct {
    logic                      allowed;
    logic                      region_ok;
    logic signed [COORD_W-1:0] rx;
    logic signed [COORD_W-1:0] ry;
    logic [SIZE_W-1:0]         rw;
    logic [SIZE_W-1:0]         rh;
    logic                      last;
  } gap_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [MODE_W-1:0]     s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  // predictor copy of the table and registers
  logic                      slot_used [SLOTS];
  logic signed [COORD_W-1:0] tab_x [SLOTS];
  logic signed [COORD_W-1:0] tab_y [SLOTS];
  logic [SIZE_W-1:0]         tab_w [SLOTS];
  logic [SIZE_W-1:0]         tab_h [SLOTS];
  logic [CFG_W-1:0]          cur_min_grid;
  logic [CFG_W-1:0]          cur_grid_size;

  gap_result_t pending_results [$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_request = 0;
  int          hold_left = 0;

  box_min_gap_checker dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint gap_clamped(longint a, longint aw, longint b, longint bw);
    longint g1;
    longint g2;
    g1 = b - (a + aw);
    g2 = a - (b + bw);
    if (g2 > g1) g1 = g2;
    return (g1 > 0) ? g1 : 0;
  endfunction

  task automatic push_plain(logic allowed);
    gap_result_t r;
    r.allowed = allowed;
    r.region_ok = 1'b0;
    r.rx = '0;
    r.ry = '0;
    r.rw = '0;
    r.rh = '0;
    r.last = 1'b1;
    pending_results.insert(pending_results.size(), r);
  endtask

  task automatic predict_box_table(logic [MODE_W-1:0] mode, logic [SLOT_W-1:0] slot,
                                   logic signed [COORD_W-1:0] px,
                                   logic signed [COORD_W-1:0] py,
                                   logic [SIZE_W-1:0] bw, logic [SIZE_W-1:0] bh);
    longint      prod;
    longint      margin;
    longint      dx;
    longint      dy;
    logic        ok;
    int          count;
    int          k;
    gap_result_t r;
    prod = longint'(cur_min_grid) * longint'(cur_grid_size);
    margin = prod >>> 8;
    case (mode)
      MODE_WRITE: begin
        tab_x[slot] = px;
        tab_y[slot] = py;
        tab_w[slot] = bw;
        tab_h[slot] = bh;
        slot_used[slot] = 1'b1;
        push_plain(1'b1);
      end
      MODE_CLEAR: begin
        slot_used[slot] = 1'b0;
        push_plain(1'b1);
      end
      MODE_CHECK: begin
        ok = 1'b1;
        if (slot_used[slot]) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (i != slot && slot_used[i] && ok) begin
              dx = gap_clamped(px, tab_w[slot], tab_x[i], tab_w[i]);
              dy = gap_clamped(py, tab_h[slot], tab_y[i], tab_h[i]);
              if (dx * 256 < prod && dy * 256 < prod) ok = 1'b0;
            end
          end
        end
        push_plain(ok);
      end
      default: begin
        count = 0;
        if (slot_used[slot]) begin
          for (int i = 0; i < SLOTS; i++)
            if (i != slot && slot_used[i]) count++;
        end
        if (count == 0) begin
          push_plain(1'b1);
        end else begin
          k = 0;
          for (int i = 0; i < SLOTS; i++) begin
            if (i != slot && slot_used[i]) begin
              k++;
              r.allowed = 1'b1;
              r.region_ok = 1'b1;
              r.rx = COORD_W'(sat(longint'(tab_x[i]) - margin, -524288, 524287));
              r.ry = COORD_W'(sat(longint'(tab_y[i]) - margin, -524288, 524287));
              r.rw = SIZE_W'(sat(longint'(tab_w[i]) + 2 * margin, 0, 524287));
              r.rh = SIZE_W'(sat(longint'(tab_h[i]) + 2 * margin, 0, 524287));
              r.last = (k == count);
              pending_results.insert(pending_results.size(), r);
            end
          end
        end
      end
    endcase
  endtask

  task automatic report_field(string name, longint expv, longint actv);
    if (expv != actv) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, expv, actv);
    end
  endtask

  // result checker: a transaction happens at the next rising edge
  always @(negedge clk) begin
    gap_result_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none actual %0h", $time, m_axis_tdata);
      end else begin
        e = pending_results.pop_front();
        report_field("move_allowed", e.allowed, m_axis_tdata[0]);
        report_field("region_valid", e.region_ok, m_axis_tuser[0]);
        report_field("region_x", e.rx, $signed(m_axis_tdata[20:1]));
        report_field("region_y", e.ry, $signed(m_axis_tdata[40:21]));
        report_field("region_width", e.rw, m_axis_tdata[59:41]);
        report_field("region_height", e.rh, m_axis_tdata[78:60]);
        report_field("last", e.last, m_axis_tlast);
      end
    end
  end

  task automatic send_item(logic [MODE_W-1:0] mode, logic [SLOT_W-1:0] slot,
                           logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py,
                           logic [SIZE_W-1:0] bw, logic [SIZE_W-1:0] bh);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, bh, bw, py, px, slot};
    do begin
      @(negedge clk);
      taken = s_axis_tready;
      @(posedge clk);
    end while (!taken);
    predict_box_table(mode, slot, px, py, bw, bh);
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    if (idx == CFG_MIN_GRID) cur_min_grid = value;
    else cur_grid_size = value;
    @(posedge clk);
  endtask

  task automatic set_margin(logic [CFG_W-1:0] min_grid, logic [CFG_W-1:0] grid);
    wait_idle();
    write_reg(CFG_MIN_GRID, min_grid);
    write_reg(CFG_GRID_SIZE, grid);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [SLOT_W-1:0] random_slot();
    return ($urandom_range(99) < 70) ? SLOT_W'($urandom_range(15)) : SLOT_W'($urandom);
  endfunction

  function automatic logic signed [COORD_W-1:0] random_coord();
    if ($urandom_range(99) < 60) return COORD_W'(int'($urandom_range(8000)) - 4000);
    return COORD_W'($urandom);
  endfunction

  function automatic logic [SIZE_W-1:0] random_size();
    return ($urandom_range(99) < 70) ? SIZE_W'($urandom_range(800)) : SIZE_W'($urandom);
  endfunction

  task automatic send_random_item(int list_pct);
    int               pick;
    logic [MODE_W-1:0] mode;
    pick = $urandom_range(99);
    if (pick < list_pct) mode = MODE_LIST;
    else if (pick < list_pct + 35) mode = MODE_CHECK;
    else if (pick < list_pct + 45) mode = MODE_CLEAR;
    else mode = MODE_WRITE;
    send_item(mode, random_slot(), random_coord(), random_coord(), random_size(),
              random_size());
  endtask

  // empty table, exact margin boundary, field extremes, saturation
  task automatic test_directed_cases();
    send_item(MODE_CHECK, 6'd5, 20'sd0, 20'sd0, '0, '0);
    send_item(MODE_LIST, 6'd5, 20'sd0, 20'sd0, '0, '0);
    send_item(MODE_WRITE, 6'd0, 20'sd0, 20'sd0, 19'd160, 19'd160);
    send_item(MODE_LIST, 6'd0, 20'sd0, 20'sd0, '0, '0);
    send_item(MODE_WRITE, 6'd1, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX);
    send_item(MODE_WRITE, 6'd63, COORD_MIN, COORD_MIN, '0, '0);
    send_item(MODE_WRITE, 6'd2, 20'sd200, 20'sd0, 19'd16, 19'd16);
    send_item(MODE_LIST, 6'd0, 20'sd0, 20'sd0, SIZE_MAX, SIZE_MAX);
    send_item(MODE_LIST, 6'd7, 20'sd0, 20'sd0, '0, '0);
    send_item(MODE_CHECK, 6'd0, 20'sd0, 20'sd0, '0, '0);
    send_item(MODE_CHECK, 6'd0, -20'sd120, 20'sd0, '0, '0);
    send_item(MODE_CHECK, 6'd0, -20'sd119, 20'sd0, '0, '0);
    send_item(MODE_CHECK, 6'd0, -20'sd400, 20'sd0, SIZE_MAX, SIZE_MAX);
    send_item(MODE_CHECK, 6'd9, 20'sd200, 20'sd0, '0, '0);
    send_item(MODE_CLEAR, 6'd2, '1, '1, SIZE_MAX, SIZE_MAX);
    send_item(MODE_CHECK, 6'd0, 20'sd0, 20'sd0, '0, '0);
    send_item(MODE_CHECK, 6'd1, COORD_MIN, COORD_MIN, '0, '0);
    send_item(MODE_CLEAR, 6'd1, '0, '0, '0, '0);
    send_item(MODE_CLEAR, 6'd63, '0, '0, '0, '0);
    send_item(MODE_LIST, 6'd0, 20'sd0, 20'sd0, '0, '0);
    send_item(MODE_WRITE, 6'd63, '1, '1, SIZE_MAX, SIZE_MAX);
    send_item(MODE_LIST, 6'd0, 20'sd0, 20'sd0, '0, '0);
    stop_sending();
  endtask

  // zero margin, smallest non-zero product and the largest margin
  task automatic test_margin_extremes();
    set_margin(16'd0, 16'd0);
    send_item(MODE_WRITE, 6'd3, 20'sd160, 20'sd0, 19'd32, 19'd32);
    send_item(MODE_CHECK, 6'd0, 20'sd0, 20'sd0, '0, '0);
    send_item(MODE_LIST, 6'd0, 20'sd0, 20'sd0, '0, '0);
    stop_sending();
    set_margin(16'd1, 16'd1);
    send_item(MODE_CHECK, 6'd0, 20'sd0, 20'sd0, '0, '0);
    send_item(MODE_CHECK, 6'd0, -20'sd1, 20'sd0, '0, '0);
    send_item(MODE_LIST, 6'd3, 20'sd0, 20'sd0, '0, '0);
    stop_sending();
    set_margin(16'hffff, 16'hffff);
    send_item(MODE_CHECK, 6'd0, COORD_MIN, COORD_MIN, '0, '0);
    send_item(MODE_LIST, 6'd0, 20'sd0, 20'sd0, '0, '0);
    send_item(MODE_LIST, 6'd3, 20'sd0, 20'sd0, '0, '0);
    stop_sending();
  endtask

  // random traffic under the four idle patterns and several margins
  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_margin(16'd256, 16'd160);
        1: set_margin(16'($urandom_range(64, 640)), 16'($urandom_range(16, 320)));
        2: set_margin(16'hffff, 16'($urandom_range(1, 64)));
        default: set_margin(16'($urandom), 16'($urandom));
      endcase
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      for (int n = 0; n < 100; n++) send_random_item(20);
      stop_sending();
    end
  endtask

  // long output hold-off while the sender keeps offering items
  task automatic test_back_pressure();
    set_margin(16'd128, 16'd160);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 1;
    for (int n = 0; n < 40; n++) send_random_item(50);
    stop_sending();
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = MODE_WRITE;
    cfg_valid = 1'b0;
    cfg_index = CFG_MIN_GRID;
    cfg_data = '0;
    cur_min_grid = MIN_GRID_RESET;
    cur_grid_size = GRID_SIZE_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i] = 1'b0;
      tab_x[i] = '0;
      tab_y[i] = '0;
      tab_w[i] = '0;
      tab_h[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_margin_extremes();
    test_random_traffic();
    test_back_pressure();
    wait_idle();
    repeat (80) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/bmg_pkg.sv
src/bmg_slot_eval.sv
src/box_min_gap_checker.sv
test/tb_top.sv
